// File: rtl/lcas_pkg.sv
// Shared package for the Life generation stream core.
// Holds grid limits, register and operation codes, stage and result types, and the B3/S23 rule.
// No dependencies.
package lcas_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT) + 1;
    localparam int CFG_W      = 11;
    localparam int REG_IDX_W  = 1;
    localparam int OUT_DEPTH  = 3;
    localparam int SLOT_W     = $clog2(OUT_DEPTH);
    localparam int LVL_W      = $clog2(OUT_DEPTH + 1);

    typedef enum logic {
        OP_CELL  = 1'b0,
        OP_FLUSH = 1'b1
    } op_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] col;
        logic             col_zero;
        logic             row_ge1;
        logic             row_ge2;
        logic             alive;
        logic             emit;
        logic             last;
    } stage_t;

    typedef struct packed {
        logic next_alive;
        logic frame_last;
    } result_t;

    function automatic logic life_rule(input logic [8:0] win);
        logic [3:0] cnt;
        cnt = 4'd0;
        for (int b = 0; b < 9; b++)
        begin
            if (b != 4)
            begin
                cnt = cnt + 4'(win[b]);
            end
        end
        if (win[4])
        begin
            return (cnt == 4'd2) || (cnt == 4'd3);
        end
        return cnt == 4'd3;
    endfunction

endpackage

// File: rtl/lcas_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// A read and a write of the same entry in one cycle return the old contents.
// No dependencies.
module lcas_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/lcas_window.sv
// Second stage: completes the upper row store update, slides the 3x3 window and applies the rule.
// Depends on lcas_pkg.
module lcas_window import lcas_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,
    input  stage_t           stage,
    input  logic             mid_rdata,
    input  logic             up_rdata,
    output logic             up_we,
    output logic [COL_W-1:0] up_waddr,
    output logic             up_wdata,
    output logic             push,
    output result_t          push_data
);

    logic [8:0] win_reg;
    logic [8:0] win_next;
    logic [8:0] shifted;
    logic       mid;
    logic       up;
    logic [2:0] newcol;

    always_comb
    begin
        mid    = stage.row_ge1 & mid_rdata;
        up     = stage.row_ge2 & up_rdata;
        newcol = {stage.alive, mid, up};
        if (stage.col_zero)
        begin
            shifted = {3'b000, win_reg[8:3]};
        end
        else
        begin
            shifted = {newcol, win_reg[8:3]};
        end

        push                 = stage.valid & stage.emit;
        push_data.next_alive = life_rule(shifted);
        push_data.frame_last = stage.last;

        up_we    = stage.valid;
        up_waddr = stage.col;
        up_wdata = mid;

        win_next = win_reg;
        if (clear)
        begin
            win_next = '0;
        end
        else if (stage.valid)
        begin
            if (stage.last)
            begin
                win_next = '0;
            end
            else if (stage.col_zero)
            begin
                win_next = {newcol, 6'b000000};
            end
            else
            begin
                win_next = shifted;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else
        begin
            win_reg <= win_next;
        end
    end

endmodule

// File: rtl/lcas_out_fifo.sv
// Output queue of results that decouples the result channel from the generation pipeline.
// Depends on lcas_pkg.
module lcas_out_fifo import lcas_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  result_t          push_data,
    input  logic             result_stall,
    output logic             result_valid,
    output result_t          result,
    output logic [LVL_W-1:0] level
);

    result_t          slot_reg [OUT_DEPTH];
    result_t          slot_next [OUT_DEPTH];
    logic [LVL_W-1:0] count_reg;
    logic [LVL_W-1:0] count_next;
    logic [LVL_W-1:0] widx;
    logic             pop;

    always_comb
    begin
        pop = (count_reg != '0) && !result_stall;
        for (int i = 0; i < OUT_DEPTH; i++)
        begin
            slot_next[i] = slot_reg[i];
        end
        if (pop)
        begin
            for (int i = 0; i < OUT_DEPTH - 1; i++)
            begin
                slot_next[i] = slot_reg[i + 1];
            end
        end
        widx = count_reg - LVL_W'(pop);
        if (push)
        begin
            slot_next[widx[SLOT_W-1:0]] = push_data;
        end
        count_next = count_reg + LVL_W'(push) - LVL_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < OUT_DEPTH; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign result_valid = (count_reg != '0);
    assign result       = slot_reg[0];
    assign level        = count_reg;

endmodule

// File: rtl/life_cellular_automaton_stream_core.sv
// Top level of the Life (B3/S23) generation stream core.
// Depends on lcas_pkg, lcas_ram, lcas_window and lcas_out_fifo.
//
// The block takes one cell request per clock cycle in raster order and returns the next
// generation of each cell in the same order, grid_width+1 requests behind the input; after a
// frame the host sends grid_width+1 flush requests to drain the last row. Each request passes
// through the scan stage, where the middle row store is read and written, and then the
// window stage, which writes the upper row store back from the value just read; its result
// is then registered in the output queue. A three-entry output queue keeps the input open
// while results wait, and the input stalls only once that queue and the window stage hold three
// results between them. The row stores need no clearing after reset, since every row is written
// in full before it is read.
module life_cellular_automaton_stream_core import lcas_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic                 op,
    input  logic                 cell_alive,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic                 next_alive,
    output logic                 frame_last,
    input  logic                 cfg_write_en,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [COL_W-1:0] wlast_reg;
    logic [COL_W-1:0] wlast_next;
    logic [ROW_W-1:0] height_reg;
    logic [ROW_W-1:0] height_next;
    logic [ROW_W-1:0] height_p1_reg;
    logic [ROW_W-1:0] height_p1_next;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    stage_t           s1_reg;
    stage_t           s1_next;
    logic             fwd_valid_reg;
    logic             fwd_valid_next;
    logic             fwd_data_reg;

    logic [31:0]      cfg_value;
    logic [COL_W:0]   width_clamp;
    logic [ROW_W-1:0] height_clamp;
    logic             accept;
    logic [COL_W-1:0] col_now;
    logic [LVL_W:0]   pending;
    logic [LVL_W-1:0] level;

    logic             mid_rdata;
    logic             up_rdata;
    logic             up_cell;
    logic             up_we;
    logic [COL_W-1:0] up_waddr;
    logic             up_wdata;
    logic             push;
    result_t          push_data;
    result_t          result;

    always_comb
    begin
        cfg_value = 32'(cfg_data);
        if (cfg_value == 32'd0)
        begin
            width_clamp  = (COL_W+1)'(1);
            height_clamp = ROW_W'(1);
        end
        else
        begin
            width_clamp  = (cfg_value > 32'(MAX_WIDTH)) ? (COL_W+1)'(MAX_WIDTH)
                                                        : (COL_W+1)'(cfg_value);
            height_clamp = (cfg_value > 32'(MAX_HEIGHT)) ? ROW_W'(MAX_HEIGHT)
                                                         : ROW_W'(cfg_value);
        end

        wlast_next     = wlast_reg;
        height_next    = height_reg;
        height_p1_next = height_p1_reg;
        if (cfg_write_en)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_GRID_WIDTH:
                begin
                    wlast_next = COL_W'(width_clamp - (COL_W+1)'(1));
                end
                REG_GRID_HEIGHT:
                begin
                    height_next    = height_clamp;
                    height_p1_next = height_clamp + ROW_W'(1);
                end
            endcase
        end
    end

    always_comb
    begin
        pending    = {1'b0, level} + (LVL_W+1)'(s1_reg.valid & s1_reg.emit);
        item_stall = (pending >= (LVL_W+1)'(OUT_DEPTH));
        accept     = item_valid && !item_stall;

        col_now          = (col_reg > wlast_reg) ? '0 : col_reg;
        s1_next.valid    = accept;
        s1_next.col      = col_now;
        s1_next.col_zero = (col_now == '0);
        s1_next.row_ge1  = (row_reg != '0);
        s1_next.row_ge2  = (row_reg[ROW_W-1:1] != '0);
        s1_next.alive    = (op == OP_CELL) && (row_reg < height_reg) && cell_alive;
        s1_next.emit     = s1_next.col_zero ? s1_next.row_ge2 : s1_next.row_ge1;
        s1_next.last     = s1_next.emit && s1_next.col_zero && (row_reg == height_p1_reg);

        fwd_valid_next = accept && s1_reg.valid && (s1_reg.col == col_now);

        col_next = col_reg;
        row_next = row_reg;
        if (cfg_write_en)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (s1_next.last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_now == wlast_reg)
            begin
                col_next = '0;
                if (row_reg != '1)
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            else
            begin
                col_next = col_now + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlast_reg     <= COL_W'(MAX_WIDTH - 1);
            height_reg    <= ROW_W'(MAX_HEIGHT);
            height_p1_reg <= ROW_W'(MAX_HEIGHT + 1);
            col_reg       <= '0;
            row_reg       <= '0;
            s1_reg        <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            wlast_reg     <= wlast_next;
            height_reg    <= height_next;
            height_p1_reg <= height_p1_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            s1_reg        <= s1_next;
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= up_wdata;
    end

    assign up_cell = fwd_valid_reg ? fwd_data_reg : up_rdata;

    lcas_ram #(
        .WIDTH (1),
        .DEPTH (MAX_WIDTH)
    ) u_mid_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (col_now),
        .wdata (s1_next.alive),
        .re    (accept),
        .raddr (col_now),
        .rdata (mid_rdata)
    );

    lcas_ram #(
        .WIDTH (1),
        .DEPTH (MAX_WIDTH)
    ) u_up_ram (
        .clk   (clk),
        .we    (up_we),
        .waddr (up_waddr),
        .wdata (up_wdata),
        .re    (accept),
        .raddr (col_now),
        .rdata (up_rdata)
    );

    lcas_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (cfg_write_en),
        .stage     (s1_reg),
        .mid_rdata (mid_rdata),
        .up_rdata  (up_cell),
        .up_we     (up_we),
        .up_waddr  (up_waddr),
        .up_wdata  (up_wdata),
        .push      (push),
        .push_data (push_data)
    );

    lcas_out_fifo u_out_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .push_data    (push_data),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result),
        .level        (level)
    );

    assign next_alive = result.next_alive;
    assign frame_last = result.frame_last;

endmodule

// File: rtl/lcas_checker.sv
// Port-level checker for the Life generation stream core, bound to the top level.
// Depends on life_cellular_automaton_stream_core.
module lcas_checker (
    input logic clk,
    input logic rst_n,
    input logic item_valid,
    input logic item_stall,
    input logic result_valid,
    input logic result_stall,
    input logic next_alive,
    input logic frame_last
);

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("Stalled result request was withdrawn.");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(next_alive) && $stable(frame_last))
        else $error("Stalled result request changed its payload.");

    a_open_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !item_stall)
        else $error("Input stalled although no result is waiting.");

    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && !item_stall, 2))
        else $error("Result appeared without a request taken two cycles earlier.");

endmodule

bind life_cellular_automaton_stream_core lcas_checker u_lcas_checker (.*);

// File: dv/life_stream_checker.sv
// Checker for the Life generation stream core: watches the request, result and register ports.
// Predicts each next-generation cell from its own copy of the row stores and window state.
// Depends on lcas_pkg for the grid limits, register and operation codes and the result type.
module life_stream_checker import lcas_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic                 item_stall,
    input  logic                 op,
    input  logic                 cell_alive,
    input  logic                 result_valid,
    input  logic                 result_stall,
    input  logic                 next_alive,
    input  logic                 frame_last,
    input  logic                 cfg_write_en,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   mismatch_count,
    output int                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ROW_CEILING = 2047;

    logic             upper_row [MAX_WIDTH];
    logic             middle_row [MAX_WIDTH];
    logic [8:0]       hood;
    logic [COL_W-1:0] scan_col;
    logic [ROW_W-1:0] scan_row;
    int unsigned      emitted;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    result_t          next_gen_q[$];
    result_t          oldest;
    int               failures;

    assign mismatch_count = failures;

    function automatic logic b3s23(input logic [8:0] cells);
        int live;
        live = $countones(cells) - int'(cells[4]);
        return (live == 3) || (cells[4] && live == 2);
    endfunction

    function automatic int unsigned effective_dim(input logic [CFG_W-1:0] value,
                                                  input int unsigned ceiling);
        if (value == '0)
        begin
            return 1;
        end
        if (value > ceiling)
        begin
            return ceiling;
        end
        return 32'(value);
    endfunction

    task automatic restart_frame();
        scan_col = '0;
        scan_row = '0;
        emitted  = 0;
        hood     = '0;
    endtask

    task automatic predict_cell(input logic is_flush, input logic alive);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        logic        v;
        logic        up;
        logic        mid;
        logic [2:0]  fresh;
        logic        emit;
        result_t     res;
        w = effective_dim(width_reg, MAX_WIDTH);
        h = effective_dim(height_reg, MAX_HEIGHT);
        c = 32'(scan_col);
        r = 32'(scan_row);
        if (c >= w)
        begin
            c = 0;
        end
        v   = (!is_flush && r < h) ? alive : 1'b0;
        up  = (r >= 2) ? upper_row[c] : 1'b0;
        mid = (r >= 1) ? middle_row[c] : 1'b0;
        upper_row[c]  = mid;
        middle_row[c] = v;
        fresh = {v, mid, up};
        emit  = 1'b0;
        if (c == 0)
        begin
            if (r >= 2)
            begin
                hood = {3'b000, hood[8:3]};
                emit = 1'b1;
            end
        end
        else
        begin
            hood = {fresh, hood[8:3]};
            emit = (r >= 1);
        end
        if (emit)
        begin
            res.next_alive = b3s23(hood);
            res.frame_last = (emitted + 1 >= w * h);
            next_gen_q.push_back(res);
            if (res.frame_last)
            begin
                restart_frame();
                return;
            end
            emitted++;
        end
        if (c == 0)
        begin
            hood = {fresh, 6'b000000};
        end
        if (c + 1 >= w)
        begin
            scan_col = '0;
            if (r < ROW_CEILING)
            begin
                scan_row = ROW_W'(r + 1);
            end
        end
        else
        begin
            scan_col = COL_W'(c + 1);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WIDTH; i++)
            begin
                upper_row[i]  = 1'b0;
                middle_row[i] = 1'b0;
            end
            width_reg  = CFG_W'(MAX_WIDTH);
            height_reg = CFG_W'(MAX_HEIGHT);
            restart_frame();
            next_gen_q.delete();
            failures = 0;
            outstanding <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (next_gen_q.size() == 0)
                begin
                    $error("result with no prediction waiting: next_alive %0b frame_last %0b",
                           next_alive, frame_last);
                    failures++;
                end
                else
                begin
                    oldest = next_gen_q.pop_front();
                    if (next_alive !== oldest.next_alive)
                    begin
                        $error("next_alive: expected %0b, got %0b", oldest.next_alive,
                               next_alive);
                        failures++;
                    end
                    if (frame_last !== oldest.frame_last)
                    begin
                        $error("frame_last: expected %0b, got %0b", oldest.frame_last,
                               frame_last);
                        failures++;
                    end
                end
            end
            if (cfg_write_en)
            begin
                if (cfg_index == REG_GRID_WIDTH)
                begin
                    width_reg = cfg_data;
                end
                else
                begin
                    height_reg = cfg_data;
                end
                restart_frame();
            end
            if (item_valid && !item_stall)
            begin
                predict_cell(op == OP_FLUSH, cell_alive);
            end
            outstanding <= next_gen_q.size();
        end
    end

endmodule

// File: dv/life_cellular_automaton_stream_core_test.sv
// Top of the Life generation stream core testbench: clock, reset, requests, register writes.
// Depends on lcas_pkg, the core and life_stream_checker, which predicts and compares results.
// Directed grids come first, then the tallest grid, then random small grids with noise.
module life_cellular_automaton_stream_core_test;
    import lcas_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             item_valid = 1'b0;
    logic             item_stall;
    op_t              item_op = OP_CELL;
    logic             cell_alive = 1'b0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    logic             next_alive;
    logic             frame_last;
    logic             cfg_write_en = 1'b0;
    reg_index_t       cfg_index = REG_GRID_WIDTH;
    logic [CFG_W-1:0] cfg_data = '0;
    int               mismatch_count;
    int               outstanding;

    int unsigned      grid_w = MAX_WIDTH;
    int unsigned      grid_h = MAX_HEIGHT;
    int               gap_percent = 0;
    int               stall_percent = 0;
    bit               calm = 1'b0;
    int               requests_sent = 0;
    int               random_start;

    life_cellular_automaton_stream_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .op           (item_op),
        .cell_alive   (cell_alive),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .next_alive   (next_alive),
        .frame_last   (frame_last),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    life_stream_checker generation_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .op             (item_op),
        .cell_alive     (cell_alive),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .next_alive     (next_alive),
        .frame_last     (frame_last),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always #5 clk = ~clk;

    task automatic send_request(input op_t kind, input logic alive);
        if (!calm && $urandom_range(0, 99) < gap_percent)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item_op    <= kind;
        cell_alive <= alive;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        requests_sent++;
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        wait_drained();
        repeat (8) @(posedge clk);
    endtask

    task automatic set_grid(input logic [CFG_W-1:0] width_val,
                            input logic [CFG_W-1:0] height_val);
        wait_idle();
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_GRID_WIDTH;
        cfg_data     <= width_val;
        @(posedge clk);
        cfg_index    <= REG_GRID_HEIGHT;
        cfg_data     <= height_val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        grid_w = (width_val == 0) ? 1 : ((width_val > MAX_WIDTH) ? MAX_WIDTH : width_val);
        grid_h = (height_val == 0) ? 1 : ((height_val > MAX_HEIGHT) ? MAX_HEIGHT : height_val);
    endtask

    task automatic send_frame(input int density, input int noise_percent,
                              input bit truncate, input bit hold);
        int   cells;
        int   total;
        int   count;
        op_t  kind;
        cells = grid_w * grid_h;
        total = cells + grid_w + 1;
        count = truncate ? $urandom_range(1, total - 1) : total;
        for (int i = 0; i < count; i++)
        begin
            kind = (i < cells) ? OP_CELL : OP_FLUSH;
            if ($urandom_range(0, 99) < noise_percent)
            begin
                kind = (kind == OP_CELL) ? OP_FLUSH : OP_CELL;
            end
            if (hold && i == count / 2)
            begin
                wait_drained();
            end
            send_request(kind, $urandom_range(0, 99) < density);
            if (requests_sent > random_start + 600)
            begin
                calm = 1'b1;
            end
        end
        if (truncate)
        begin
            set_grid(CFG_W'(grid_w), CFG_W'(grid_h));
        end
    endtask

    function automatic logic [CFG_W-1:0] pick_dim();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
        begin
            return '0;
        end
        if (pick < 14)
        begin
            return CFG_W'($urandom_range(1, 6));
        end
        return CFG_W'($urandom_range(7, 24));
    endfunction

    function automatic int pick_percent();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 15;
            default: return 40;
        endcase
    endfunction

    function automatic int pick_density();
        case ($urandom_range(0, 3))
            0: return 10;
            1: return 35;
            2: return 50;
            default: return 80;
        endcase
    endfunction

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 99) < stall_percent)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int frames;
        logic [CFG_W-1:0] width_val;
        logic [CFG_W-1:0] height_val;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A horizontal blinker on a 3x3 grid turns vertical.
        set_grid(11'd3, 11'd3);
        for (int i = 0; i < 9; i++)
        begin
            send_request(OP_CELL, i >= 3 && i <= 5);
        end
        repeat (4) send_request(OP_FLUSH, 1'b1);

        // Zero in both registers reads as a single cell.
        set_grid(11'd0, 11'd0);
        send_request(OP_CELL, 1'b1);
        repeat (2) send_request(OP_FLUSH, 1'b0);

        // A register write part-way through a frame starts it again; a flush request inside
        // the grid and cell requests below the last row both count as dead cells.
        set_grid(11'd2, 11'd2);
        repeat (3) send_request(OP_CELL, 1'b1);
        set_grid(11'd2, 11'd2);
        send_request(OP_CELL, 1'b1);
        send_request(OP_FLUSH, 1'b1);
        send_request(OP_CELL, 1'b1);
        send_request(OP_CELL, 1'b1);
        send_request(OP_CELL, 1'b1);
        send_request(OP_CELL, 1'b1);
        send_request(OP_FLUSH, 1'b0);

        gap_percent   = 15;
        stall_percent = 15;
        random_start  = requests_sent + 100000;
        set_grid(11'd0, 11'd2047);
        send_frame(35, 0, 1'b0, 1'b1);

        random_start = requests_sent;
        while (requests_sent < random_start + 750)
        begin
            width_val     = pick_dim();
            height_val    = pick_dim();
            gap_percent   = pick_percent();
            stall_percent = pick_percent();
            set_grid(width_val, height_val);
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++)
            begin
                send_frame(pick_density(), ($urandom_range(0, 3) == 0) ? 4 : 0,
                           $urandom_range(0, 9) == 0, $urandom_range(0, 7) == 0);
            end
        end

        wait_idle();
        if (mismatch_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: life_cellular_automaton_stream_core.f
rtl/lcas_pkg.sv
rtl/lcas_ram.sv
rtl/lcas_window.sv
rtl/lcas_out_fifo.sv
rtl/life_cellular_automaton_stream_core.sv
rtl/lcas_checker.sv
dv/life_stream_checker.sv
dv/life_cellular_automaton_stream_core_test.sv
